// ----- src/rfalu_pkg.sv -----
// ----------------------------------------------------------------------------
// rfalu_pkg
// shared widths, operation codes and sequencer states for the fraction alu
// ----------------------------------------------------------------------------
package rfalu_pkg;

    localparam int IN_WIDTH_DEF  = 16;
    localparam int NUM_OUT_WIDTH = 33;
    localparam int DEN_OUT_WIDTH = 31;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_MUL1 = 8'b0000_0010,
        ST_MUL2 = 8'b0000_0100,
        ST_MUL3 = 8'b0000_1000,
        ST_GCD  = 8'b0001_0000,
        ST_DIVN = 8'b0010_0000,
        ST_DIVD = 8'b0100_0000,
        ST_OUT  = 8'b1000_0000
    } state_t;

endpackage

// ----- src/rational_fraction_alu_core.sv -----
// ----------------------------------------------------------------------------
// rational_fraction_alu_core
// exact add, subtract, multiply or divide of two fractions, gcd reduced
// ----------------------------------------------------------------------------
//  channel | direction | ports
//  s_      | in        | s_valid s_ready s_op s_a_num s_a_den s_b_num s_b_den
//  m_      | out       | m_valid m_ready m_res_num m_res_den m_status
//
//  one shared adder/subtractor serves the cross products (shift-add, one bit
//  a cycle), the signed combine, the binary gcd (one step a cycle) and two
//  restoring divisions (one quotient bit a cycle). an error result is
//  presented the cycle after its transfer. one item at a time: s_ready is
//  high only when idle and the result register is free. no clearing pass
//  after reset.
// ----------------------------------------------------------------------------
module rational_fraction_alu_core #(
    parameter int IN_WIDTH = rfalu_pkg::IN_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [1:0]                           s_op,
    input  logic signed [IN_WIDTH-1:0]           s_a_num,
    input  logic [IN_WIDTH-2:0]                  s_a_den,
    input  logic signed [IN_WIDTH-1:0]           s_b_num,
    input  logic [IN_WIDTH-2:0]                  s_b_den,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [rfalu_pkg::NUM_OUT_WIDTH-1:0] m_res_num,
    output logic [rfalu_pkg::DEN_OUT_WIDTH-1:0]  m_res_den,
    output logic                                 m_status
);

    localparam int W  = 2 * IN_WIDTH + 1;          // magnitude width
    localparam int CW = $clog2(W + 1);

    rfalu_pkg::state_t state_reg, state_next;

    logic [W-1:0]   n_reg, d_reg;         // exact magnitudes
    logic [W-1:0]   x_reg, y_reg;         // gcd working pair / divisor
    logic [W-1:0]   p_reg, q_reg, r_reg;  // product/dividend/quotient, unused, remainder
    logic [W-1:0]   m_reg;                // multiplicand
    logic [W-1:0]   t_reg;                // first cross product
    logic [CW-1:0]  k_reg;                // common power of two
    logic [CW-1:0]  cnt_reg;
    logic           neg_reg;
    logic           ovalid_reg, ostat_reg;
    logic [1:0]     op_reg;
    logic [IN_WIDTH-1:0] an_mag_reg, bn_mag_reg;
    logic           an_neg_reg, bn_neg_reg;
    logic [IN_WIDTH-2:0] ad_reg, bd_reg;
    logic [W-1:0]   rn_reg, rd_reg;

    // shared adder/subtractor
    logic [W-1:0] au_a, au_b;
    logic         au_sub;
    logic [W:0]   au_y;
    assign au_y = au_sub ? ({1'b0, au_a} - {1'b0, au_b}) : ({1'b0, au_a} + {1'b0, au_b});

    // cross products of opposite sign are subtracted
    logic mix_sign;
    assign mix_sign = an_neg_reg ^ bn_neg_reg ^ (op_reg == rfalu_pkg::OP_SUB);

    logic [IN_WIDTH-1:0] an_abs, bn_abs;
    assign an_abs = s_a_num[IN_WIDTH-1] ? IN_WIDTH'(-s_a_num) : IN_WIDTH'(s_a_num);
    assign bn_abs = s_b_num[IN_WIDTH-1] ? IN_WIDTH'(-s_b_num) : IN_WIDTH'(s_b_num);

    logic in_err;
    assign in_err = (s_a_den == '0) || (s_b_den == '0)
                 || ((s_op == rfalu_pkg::OP_DIV) && (s_b_num == '0));

    assign s_ready = (state_reg == rfalu_pkg::ST_IDLE) && !ovalid_reg;
    assign m_valid = ovalid_reg;
    assign m_status = ostat_reg;
    assign m_res_num = neg_reg ? -rfalu_pkg::NUM_OUT_WIDTH'(rn_reg)
                               : rfalu_pkg::NUM_OUT_WIDTH'(rn_reg);
    assign m_res_den = rfalu_pkg::DEN_OUT_WIDTH'(rd_reg);

    // multiplier operand selection per pass
    logic [W-1:0] mplier;
    always_comb begin
        mplier = '0;
        case (state_reg)
            rfalu_pkg::ST_MUL1: mplier = (op_reg == rfalu_pkg::OP_MUL)
                                       ? W'(bn_mag_reg) : W'(bd_reg);
            rfalu_pkg::ST_MUL2: mplier = (op_reg == rfalu_pkg::OP_DIV)
                                       ? W'(bn_mag_reg) : W'(bd_reg);
            default:            mplier = W'(ad_reg);
        endcase
    end

    // adder operand selection
    always_comb begin
        au_a = p_reg;
        au_b = m_reg;
        au_sub = 1'b0;
        case (state_reg)
            rfalu_pkg::ST_GCD: begin
                au_a = (x_reg >= y_reg) ? x_reg : y_reg;
                au_b = (x_reg >= y_reg) ? y_reg : x_reg;
                au_sub = 1'b1;
            end
            rfalu_pkg::ST_DIVN, rfalu_pkg::ST_DIVD: begin
                au_a = {r_reg[W-2:0], p_reg[W-1]};
                au_b = y_reg;
                au_sub = 1'b1;
            end
            rfalu_pkg::ST_OUT: begin
                au_a = (t_reg >= p_reg) ? t_reg : p_reg;
                au_b = (t_reg >= p_reg) ? p_reg : t_reg;
                au_sub = mix_sign;
            end
            default: ;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rfalu_pkg::ST_IDLE: if (s_valid && s_ready && !in_err)
                                    state_next = rfalu_pkg::ST_MUL1;
            rfalu_pkg::ST_MUL1: if (cnt_reg == CW'(IN_WIDTH - 1))
                                    state_next = rfalu_pkg::ST_MUL2;
            rfalu_pkg::ST_MUL2: if (cnt_reg == CW'(IN_WIDTH - 1))
                                    state_next = rfalu_pkg::ST_MUL3;
            rfalu_pkg::ST_MUL3: if (cnt_reg == CW'(IN_WIDTH - 1))
                                    state_next = rfalu_pkg::ST_OUT;
            rfalu_pkg::ST_OUT:  state_next = rfalu_pkg::ST_GCD;
            rfalu_pkg::ST_GCD:  if (x_reg == '0 || y_reg == '0 || x_reg == y_reg)
                                    state_next = rfalu_pkg::ST_DIVN;
            rfalu_pkg::ST_DIVN: if (cnt_reg == CW'(W - 1))
                                    state_next = rfalu_pkg::ST_DIVD;
            rfalu_pkg::ST_DIVD: if (cnt_reg == CW'(W - 1))
                                    state_next = rfalu_pkg::ST_IDLE;
            default:            state_next = rfalu_pkg::ST_IDLE;
        endcase
    end

    logic [W-1:0] g_full;
    assign g_full = ((x_reg == '0) ? y_reg : x_reg) << k_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= rfalu_pkg::ST_IDLE;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (m_valid && m_ready)
                ovalid_reg <= 1'b0;
            unique case (state_reg)
                rfalu_pkg::ST_IDLE: begin
                    cnt_reg <= '0;
                    if (s_valid && s_ready) begin
                        op_reg     <= s_op;
                        an_mag_reg <= an_abs;
                        bn_mag_reg <= bn_abs;
                        an_neg_reg <= s_a_num[IN_WIDTH-1];
                        bn_neg_reg <= s_b_num[IN_WIDTH-1];
                        ad_reg     <= s_a_den;
                        bd_reg     <= s_b_den;
                        p_reg      <= '0;
                        m_reg      <= W'(an_abs);
                        if (in_err) begin
                            ovalid_reg <= 1'b1;
                            ostat_reg  <= 1'b1;
                            neg_reg    <= 1'b0;
                            rn_reg     <= '0;
                            rd_reg     <= '0;
                        end
                    end
                end
                // shift-add multiply, one multiplier bit a cycle
                rfalu_pkg::ST_MUL1, rfalu_pkg::ST_MUL2, rfalu_pkg::ST_MUL3: begin
                    if (mplier[cnt_reg[CW-1:0]])
                        p_reg <= au_y[W-1:0];
                    m_reg   <= m_reg << 1;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CW'(IN_WIDTH - 1)) begin
                        cnt_reg <= '0;
                        if (state_reg == rfalu_pkg::ST_MUL1) begin
                            t_reg <= mplier[cnt_reg] ? au_y[W-1:0] : p_reg;
                            p_reg <= '0;
                            m_reg <= W'(ad_reg);
                        end else if (state_reg == rfalu_pkg::ST_MUL2) begin
                            // second product: a_den*b_den, or a_den*|b_num| for divide
                            d_reg <= mplier[cnt_reg] ? au_y[W-1:0] : p_reg;
                            p_reg <= '0;
                            m_reg <= W'(bn_mag_reg);
                        end else begin
                            // third pass gives |b_num|*a_den for add/subtract
                            p_reg <= mplier[cnt_reg] ? au_y[W-1:0] : p_reg;
                        end
                    end
                end
                // combine cross products with signs; multiply and divide take the first product
                rfalu_pkg::ST_OUT: begin
                    logic sa, sb;
                    logic [W-1:0] nm;
                    logic         nn;
                    sa = an_neg_reg;
                    sb = bn_neg_reg ^ (op_reg == rfalu_pkg::OP_SUB);
                    nm = au_y[W-1:0];
                    nn = (t_reg >= p_reg) ? sa : sb;
                    if (op_reg == rfalu_pkg::OP_MUL || op_reg == rfalu_pkg::OP_DIV) begin
                        nm = t_reg;
                        nn = an_neg_reg ^ bn_neg_reg;
                    end
                    n_reg   <= nm;
                    neg_reg <= nn && (nm != '0);
                    x_reg   <= nm;
                    y_reg   <= d_reg;
                    k_reg   <= '0;
                end
                // binary gcd, one step a cycle
                rfalu_pkg::ST_GCD: begin
                    if (!(x_reg == '0 || y_reg == '0 || x_reg == y_reg)) begin
                        if (!x_reg[0] && !y_reg[0]) begin
                            x_reg <= x_reg >> 1;
                            y_reg <= y_reg >> 1;
                            k_reg <= k_reg + 1'b1;
                        end else if (!x_reg[0]) begin
                            x_reg <= x_reg >> 1;
                        end else if (!y_reg[0]) begin
                            y_reg <= y_reg >> 1;
                        end else if (x_reg >= y_reg) begin
                            x_reg <= au_y[W-1:0] >> 1;
                        end else begin
                            y_reg <= au_y[W-1:0] >> 1;
                        end
                    end else begin
                        y_reg   <= (n_reg == '0) ? W'(1) : g_full;
                        p_reg   <= n_reg;
                        r_reg   <= '0;
                        cnt_reg <= '0;
                    end
                end
                // restoring division, numerator then denominator
                rfalu_pkg::ST_DIVN, rfalu_pkg::ST_DIVD: begin
                    logic [W-1:0] rs;
                    rs = {r_reg[W-2:0], p_reg[W-1]};
                    p_reg <= {p_reg[W-2:0], ~au_y[W]};
                    r_reg <= au_y[W] ? rs : au_y[W-1:0];
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CW'(W - 1)) begin
                        cnt_reg <= '0;
                        r_reg   <= '0;
                        if (state_reg == rfalu_pkg::ST_DIVN) begin
                            rn_reg <= {p_reg[W-2:0], ~au_y[W]};
                            p_reg  <= d_reg;
                        end else begin
                            rd_reg     <= (n_reg == '0) ? W'(1) : {p_reg[W-2:0], ~au_y[W]};
                            ostat_reg  <= 1'b0;
                            ovalid_reg <= 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != rfalu_pkg::ST_IDLE) |-> !s_ready)
        else $error("ready while busy");
    a_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("state not one-hot");
    a_err_den: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status) |-> (m_res_den == '0 && m_res_num == '0))
        else $error("error result not zero");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_res_den)))
        else $error("result dropped while stalled");
`endif

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// checks the fraction alu against an independent exact-arithmetic predictor;
// directed corner cases, random traffic with random gaps on both sides, a
// long output stall and a drain pause
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IW = rfalu_pkg::IN_WIDTH_DEF;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic signed [rfalu_pkg::NUM_OUT_WIDTH-1:0] num;
        logic [rfalu_pkg::DEN_OUT_WIDTH-1:0]        den;
        logic                                       status;
    } fraction_result_t;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    logic [1:0] s_op;
    logic signed [IW-1:0] s_a_num;
    logic [IW-2:0] s_a_den;
    logic signed [IW-1:0] s_b_num;
    logic [IW-2:0] s_b_den;
    logic m_valid;
    logic m_ready;
    logic signed [rfalu_pkg::NUM_OUT_WIDTH-1:0] m_res_num;
    logic [rfalu_pkg::DEN_OUT_WIDTH-1:0] m_res_den;
    logic m_status;

    fraction_result_t expected_fractions[$];
    int  error_count;
    longint cycle_count;
    bit  sink_hold;
    bit  sink_gaps_on;

    rational_fraction_alu_core #(.IN_WIDTH(IW)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_op(s_op),
        .s_a_num(s_a_num), .s_a_den(s_a_den), .s_b_num(s_b_num), .s_b_den(s_b_den),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_res_num(m_res_num), .m_res_den(m_res_den), .m_status(m_status)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // exact reduced result of one operation
    function automatic fraction_result_t reduce_fraction(rfalu_pkg::op_t op, longint an,
                                                         longint ad, longint bn,
                                                         longint bd);
        fraction_result_t r;
        longint n, d, un, ud, x, y, t;
        bit neg;
        r = '0;
        if (ad == 0 || bd == 0 || (op == rfalu_pkg::OP_DIV && bn == 0)) begin
            r.status = 1'b1;
            return r;
        end
        case (op)
            rfalu_pkg::OP_ADD: begin n = an * bd + bn * ad; d = ad * bd; end
            rfalu_pkg::OP_SUB: begin n = an * bd - bn * ad; d = ad * bd; end
            rfalu_pkg::OP_MUL: begin n = an * bn; d = ad * bd; end
            default: begin n = an * bd; d = ad * bn; end
        endcase
        neg = ((n < 0) != (d < 0)) && n != 0;
        un = (n < 0) ? -n : n;
        ud = (d < 0) ? -d : d;
        if (un == 0) begin
            ud = 1;
        end else begin
            x = un;
            y = ud;
            while (y != 0) begin
                t = x % y;
                x = y;
                y = t;
            end
            un = un / x;
            ud = ud / x;
        end
        r.num = rfalu_pkg::NUM_OUT_WIDTH'(neg ? -un : un);
        r.den = rfalu_pkg::DEN_OUT_WIDTH'(ud);
        return r;
    endfunction

    // send one item, predicting its result on transfer
    task automatic send_fraction(rfalu_pkg::op_t op, logic signed [IW-1:0] an,
                                 logic [IW-2:0] ad, logic signed [IW-1:0] bn,
                                 logic [IW-2:0] bd, int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op    <= op;
        s_a_num <= an;
        s_a_den <= ad;
        s_b_num <= bn;
        s_b_den <= bd;
        do @(posedge aclk); while (!s_ready);
        expected_fractions.push_back(reduce_fraction(op, longint'(an), longint'(ad),
                                                     longint'(bn), longint'(bd)));
    endtask

    // result side: random ready, compare each transfer
    initial begin
        fraction_result_t e;
        int wait_cycles;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            wait_cycles = sink_gaps_on ? $urandom_range(0, 11) : 0;
            if (wait_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
            end
            while (sink_hold) begin
                m_ready <= 1'b0;
                @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            if (expected_fractions.size() == 0) begin
                $display("%t result expected none actual num=%0d den=%0d status=%0d",
                         $time, m_res_num, m_res_den, m_status);
                error_count++;
            end else begin
                e = expected_fractions.pop_front();
                if (m_res_num !== e.num) begin
                    $display("%t res_num expected %0d actual %0d", $time, e.num, m_res_num);
                    error_count++;
                end
                if (m_res_den !== e.den) begin
                    $display("%t res_den expected %0d actual %0d", $time, e.den, m_res_den);
                    error_count++;
                end
                if (m_status !== e.status) begin
                    $display("%t status expected %0d actual %0d", $time, e.status, m_status);
                    error_count++;
                end
            end
        end
    end

    // sender goes quiet until every result is in
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_fractions.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    // extremes, every operation, zero results, zero divisor, zero denominators
    task automatic test_directed();
        send_fraction(rfalu_pkg::OP_ADD, 16'sh7fff, 15'h7fff, 16'sh7fff, 15'h7fff, 0);
        send_fraction(rfalu_pkg::OP_ADD, -16'sd32768, 15'd1, -16'sd32768, 15'd1, 0);
        send_fraction(rfalu_pkg::OP_SUB, -16'sd32768, 15'd1, 16'sh7fff, 15'd1, 0);
        send_fraction(rfalu_pkg::OP_SUB, 16'sd3, 15'd4, 16'sd3, 15'd4, 0);
        send_fraction(rfalu_pkg::OP_MUL, -16'sd32768, 15'd1, -16'sd32768, 15'd1, 0);
        send_fraction(rfalu_pkg::OP_MUL, 16'sd0, 15'd5, 16'sd7, 15'd3, 0);
        send_fraction(rfalu_pkg::OP_MUL, 16'sh7fff, 15'd1, -16'sd32768, 15'h7fff, 0);
        send_fraction(rfalu_pkg::OP_DIV, 16'sh7fff, 15'd1, 16'sd1, 15'h7fff, 0);
        send_fraction(rfalu_pkg::OP_DIV, -16'sd32768, 15'd1, -16'sd1, 15'h7fff, 0);
        send_fraction(rfalu_pkg::OP_DIV, 16'sd5, 15'd3, 16'sd0, 15'd3, 0);
        send_fraction(rfalu_pkg::OP_DIV, 16'sd0, 15'd3, 16'sd4, 15'd9, 0);
        send_fraction(rfalu_pkg::OP_DIV, 16'sd1, 15'd2, -16'sd3, 15'd4, 0);
        send_fraction(rfalu_pkg::OP_ADD, 16'sd1, 15'd0, 16'sd1, 15'd1, 0);
        send_fraction(rfalu_pkg::OP_MUL, 16'sd1, 15'd1, 16'sd1, 15'd0, 0);
        send_fraction(rfalu_pkg::OP_SUB, 16'sd0, 15'd0, 16'sd0, 15'd0, 0);
        send_fraction(rfalu_pkg::OP_ADD, 16'sd1, 15'd3, -16'sd1, 15'd3, 0);
        send_fraction(rfalu_pkg::OP_ADD, 16'sd6, 15'd4, 16'sd10, 15'd8, 0);
        send_fraction(rfalu_pkg::OP_DIV, -16'sd1, 15'd16384, -16'sd32768, 15'd1, 0);
    endtask

    // random items with random input gaps; output gaps follow sink_gaps_on
    task automatic test_random(int count);
        logic [IW-2:0] ad, bd;
        for (int i = 0; i < count; i++) begin
            ad = ($urandom_range(0, 3) == 0) ? (IW-1)'($urandom_range(1, 16))
                                             : (IW-1)'($urandom_range(1, 32767));
            bd = ($urandom_range(0, 3) == 0) ? (IW-1)'($urandom_range(1, 16))
                                             : (IW-1)'($urandom_range(1, 32767));
            if ($urandom_range(0, 49) == 0) ad = '0;
            if ($urandom_range(0, 49) == 0) bd = '0;
            send_fraction(rfalu_pkg::op_t'($urandom_range(0, 3)), IW'($urandom), ad,
                          ($urandom_range(0, 19) == 0) ? '0 : IW'($urandom), bd,
                          (i % 60 < 10) ? 0 : int'($urandom_range(0, 11)));
        end
    endtask

    // output held off for a long stretch while items keep coming
    task automatic test_output_stall();
        sink_hold = 1'b1;
        fork
            begin
                repeat (1500) @(posedge aclk);
                sink_hold = 1'b0;
            end
            test_random(8);
        join
    endtask

    // sender pauses until all results are in, then resumes
    task automatic test_drain_pause();
        test_random(10);
        wait_drained();
        test_random(10);
    endtask

    initial begin
        error_count  = 0;
        cycle_count  = 0;
        sink_hold    = 1'b0;
        sink_gaps_on = 1'b1;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_op    = '0;
        s_a_num = '0;
        s_a_den = '0;
        s_b_num = '0;
        s_b_den = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_output_stall();
        test_drain_pause();
        test_random(250);
        sink_gaps_on = 1'b0;
        test_random(100);
        sink_gaps_on = 1'b1;
        test_random(160);
        wait_drained();
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
